FILE: rtl/mtg_pkg.sv
// Shared types, constants and functions for the MT19937 word generator.
// No dependencies; imported by the top level and the seeding sequencer.
package mtg_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 10;

  localparam logic [IDX_W-1:0]  N_WORDS    = 10'd624;
  localparam logic [IDX_W-1:0]  M_WORDS    = 10'd397;
  localparam logic [IDX_W-1:0]  FILL_LAST  = N_WORDS - 10'd1;
  localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
  localparam logic [WORD_W-1:0] UPPER_MASK = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] MATRIX_A   = 32'd2567483615;
  localparam logic [WORD_W-1:0] TEMPER_B   = 32'd2636928640;
  localparam logic [WORD_W-1:0] TEMPER_C   = 32'd4022730752;
  localparam logic [WORD_W-1:0] RESET_SEED = 32'd5489;

  // Seeding sequencer states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_PRIME,
    ST_RUN
  } mtg_state_t;

  // Control from the seeding sequencer to the datapath
  typedef struct packed {
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              prime;
    logic              run;
  } mtg_fill_t;

  // Wrap an index sum back into 0..N-1 (sum stays below 2*N)
  function automatic logic [IDX_W-1:0] idx_wrap(input logic [IDX_W:0] s);
    logic [IDX_W:0] n_ext;
    n_ext = {1'b0, N_WORDS};
    return (s >= n_ext) ? IDX_W'(s - n_ext) : IDX_W'(s);
  endfunction

  // One in-place twist step
  function automatic logic [WORD_W-1:0] twist(input logic [WORD_W-1:0] cur,
                                              input logic [WORD_W-1:0] nxt,
                                              input logic [WORD_W-1:0] far);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] w;
    y = (cur & UPPER_MASK) | (nxt & LOWER_MASK);
    w = far ^ (y >> 1);
    if (y[0]) w = w ^ MATRIX_A;
    return w;
  endfunction

  // Output tempering
  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] y;
    y = v ^ (v >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

FILE: rtl/mersenne_twister_generator.sv
// MT19937 32-bit word generator, top level. Uses mtg_pkg, mtg_ram, mtg_seed_fill.
// Latency: a result is valid the cycle after its draw transaction.
// Throughput: one word per clock; two table copies give the two reads
// (word i+1 and word i+397) and one write-back needed every cycle.
// Reset and every seed write refill the table: in_ready is low for 625 cycles
// (624 fill writes plus one cycle priming the read ports); the index returns to 0.
module mersenne_twister_generator
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              draw_request,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] random_word,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  localparam logic [IDX_W:0] PF_NEAR = 11'd2;
  localparam logic [IDX_W:0] PF_FAR  = {1'b0, M_WORDS} + 11'd1;

  mtg_fill_t         ctrl;
  logic              accept;
  logic              draw;
  logic [IDX_W-1:0]  word_index;
  logic [IDX_W-1:0]  index_inc;
  logic [WORD_W-1:0] cur_word;
  logic [WORD_W-1:0] near_word;
  logic [WORD_W-1:0] far_word;
  logic [WORD_W-1:0] twisted;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  near_raddr;
  logic [IDX_W-1:0]  far_raddr;

  mtg_seed_fill u_seed_fill (
    .clk        (clk),
    .rst        (rst),
    .seed_we    (cfg_we),
    .seed_wdata (cfg_wdata),
    .ctrl       (ctrl)
  );

  // Handshake: the output register frees as its word is taken
  assign in_ready = ctrl.run && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign draw     = accept && draw_request;

  // Twist of the current word from prefetched neighbours
  assign twisted   = twist(cur_word, near_word, far_word);
  assign index_inc = idx_wrap({1'b0, word_index} + 11'd1);

  // Table port control: fill writes, or write-back plus prefetch of i+2 / i+398
  always_comb begin
    ram_we     = ctrl.wr_en || draw;
    ram_waddr  = ctrl.wr_en ? ctrl.wr_addr : word_index;
    ram_wdata  = ctrl.wr_en ? ctrl.wr_data : twisted;
    ram_re     = ctrl.prime || draw;
    near_raddr = ctrl.prime ? 10'd1 : idx_wrap({1'b0, word_index} + PF_NEAR);
    far_raddr  = ctrl.prime ? M_WORDS : idx_wrap({1'b0, word_index} + PF_FAR);
  end

  // Copy read at index+1
  mtg_ram #(.WIDTH(WORD_W), .DEPTH(int'(N_WORDS))) u_ram_near (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (near_raddr),
    .rdata (near_word)
  );

  // Copy read at index+397
  mtg_ram #(.WIDTH(WORD_W), .DEPTH(int'(N_WORDS))) u_ram_far (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (far_raddr),
    .rdata (far_word)
  );

  // Current word: entry 0 from the fill, then the prefetched neighbour
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && (ctrl.wr_addr == '0)) cur_word <= ctrl.wr_data;
    else if (draw)                          cur_word <= near_word;
  end

  // Word index
  always_ff @(posedge clk) begin
    if (rst || ctrl.prime) word_index <= '0;
    else if (draw)         word_index <= index_inc;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (draw) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (draw) random_word <= temper(twisted);
  end

  // Assertions
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    word_index < N_WORDS)
    else $error("word index out of range");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    draw && !cfg_we |=> word_index == idx_wrap({1'b0, $past(word_index)} + 11'd1))
    else $error("word index did not advance by one");

  a_no_draw_in_fill: assert property (@(posedge clk) disable iff (rst)
    (ctrl.wr_en || ctrl.prime) |-> !draw)
    else $error("draw taken while table is being filled");

  a_draw_result: assert property (@(posedge clk) disable iff (rst)
    draw |=> out_valid)
    else $error("draw transaction produced no result");

  a_prime_then_run: assert property (@(posedge clk) disable iff (rst)
    ctrl.prime && !cfg_we |=> ctrl.run)
    else $error("priming not followed by run");

endmodule

FILE: rtl/mtg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mtg_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 624,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mtg_seed_fill.sv
// Seeding sequencer: fills the state table from the seed after reset and
// after every seed write, then primes the read ports. Uses mtg_pkg.
module mtg_seed_fill
  import mtg_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              seed_we,
  input  logic [WORD_W-1:0] seed_wdata,
  output mtg_fill_t         ctrl
);

  mtg_state_t        state;
  mtg_state_t        state_next;
  logic [IDX_W-1:0]  fill_cnt;
  logic [IDX_W-1:0]  cnt_inc;
  logic [WORD_W-1:0] fill_val;
  logic [WORD_W-1:0] fill_val_next;
  logic [WORD_W-1:0] mixed;

  // Init recurrence: t[i] = MULT * (t[i-1] ^ (t[i-1] >> 30)) + i
  always_comb begin
    cnt_inc       = fill_cnt + 10'd1;
    mixed         = fill_val ^ (fill_val >> 30);
    fill_val_next = WORD_W'(INIT_MULT * mixed) + {{(WORD_W-IDX_W){1'b0}}, cnt_inc};
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_FILL:  if (fill_cnt == FILL_LAST) state_next = ST_PRIME;
      ST_PRIME: state_next = ST_RUN;
      ST_RUN:   state_next = ST_RUN;
      default:  state_next = ST_FILL;
    endcase
  end

  // State, counter and running value; a seed write restarts the fill
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      fill_cnt <= '0;
      fill_val <= RESET_SEED;
    end else if (seed_we) begin
      state    <= ST_FILL;
      fill_cnt <= '0;
      fill_val <= seed_wdata;
    end else begin
      state <= state_next;
      if (state == ST_FILL) begin
        fill_cnt <= cnt_inc;
        fill_val <= fill_val_next;
      end
    end
  end

  // Outputs
  always_comb begin
    ctrl.wr_en   = (state == ST_FILL);
    ctrl.wr_addr = fill_cnt;
    ctrl.wr_data = fill_val;
    ctrl.prime   = (state == ST_PRIME);
    ctrl.run     = (state == ST_RUN);
  end

endmodule
